FILE: design/clx_pkg.sv
// Shared types, token codes, byte codes and keyword tables for the lexer.
// No dependencies; imported by every lexer module.
package clx_pkg;

    localparam int C_SOURCE_BYTES = 65536;
    localparam int C_QUEUE_DEPTH  = 4;
    localparam int C_GROUP_MAX    = 3;
    localparam int C_KW_COUNT     = 7;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_INTDOT,
        MODE_REAL,
        MODE_STRING,
        MODE_OP
    } t_mode;

    // token classes
    localparam logic [4:0] TK_IDENT  = 5'd0;
    localparam logic [4:0] TK_INT    = 5'd1;
    localparam logic [4:0] TK_REAL   = 5'd2;
    localparam logic [4:0] TK_STRING = 5'd3;
    localparam logic [4:0] TK_TYPE   = 5'd4;
    localparam logic [4:0] TK_ADDOP  = 5'd5;
    localparam logic [4:0] TK_MULOP  = 5'd6;
    localparam logic [4:0] TK_RELOP  = 5'd7;
    localparam logic [4:0] TK_OR     = 5'd8;
    localparam logic [4:0] TK_AND    = 5'd9;
    localparam logic [4:0] TK_NOT    = 5'd10;
    localparam logic [4:0] TK_EQOP   = 5'd11;
    localparam logic [4:0] TK_SEMI   = 5'd12;
    localparam logic [4:0] TK_COMMA  = 5'd13;
    localparam logic [4:0] TK_LPAREN = 5'd14;
    localparam logic [4:0] TK_RPAREN = 5'd15;
    localparam logic [4:0] TK_LBRACE = 5'd16;
    localparam logic [4:0] TK_RBRACE = 5'd17;
    localparam logic [4:0] TK_ASSIGN = 5'd18;
    localparam logic [4:0] TK_IF     = 5'd19;
    localparam logic [4:0] TK_WHILE  = 5'd20;
    localparam logic [4:0] TK_RETURN = 5'd21;
    localparam logic [4:0] TK_ELSE   = 5'd22;
    localparam logic [4:0] TK_DOLLAR = 5'd23;
    localparam logic [4:0] TK_ERROR  = 5'd24;

    // source bytes with a meaning of their own
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_LT         = 8'h3C;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_AMP        = 8'h26;
    localparam logic [7:0] CH_PIPE       = 8'h7C;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [16:0] len;
        logic [7:0]  first;
    } t_token;

    // all tokens caused by one source byte
    typedef struct packed {
        t_token [C_GROUP_MAX-1:0] tok;
        logic [1:0]               cnt;
    } t_group;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // keyword k, character p (zero past the end)
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
        logic [47:0] text;
        case (k)
            3'd0:    text = {"int", 24'h0};
            3'd1:    text = {"float", 8'h0};
            3'd2:    text = {"void", 16'h0};
            3'd3:    text = {"if", 32'h0};
            3'd4:    text = {"while", 8'h0};
            3'd5:    text = "return";
            3'd6:    text = {"else", 16'h0};
            default: text = '0;
        endcase
        if (p > 3'd5) begin
            return 8'h00;
        end
        return text[8*(5-int'(p)) +: 8];
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        case (k)
            3'd0:    return 3'd3;
            3'd1:    return 3'd5;
            3'd2:    return 3'd4;
            3'd3:    return 3'd2;
            3'd4:    return 3'd5;
            3'd5:    return 3'd6;
            3'd6:    return 3'd4;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [4:0] kw_type(input logic [2:0] k);
        case (k)
            3'd0, 3'd1, 3'd2: return TK_TYPE;
            3'd3:             return TK_IF;
            3'd4:             return TK_WHILE;
            3'd5:             return TK_RETURN;
            3'd6:             return TK_ELSE;
            default:          return TK_IDENT;
        endcase
    endfunction

endpackage

FILE: design/clx_front.sv
// Lexer front end: per-byte scanner state machine, builds the token group of each byte.
// Depends on clx_pkg.
module clx_front import clx_pkg::*; #(
    parameter int unsigned SOURCE_BYTES = C_SOURCE_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_source_byte,
    input  logic       i_end_of_source,
    input  t_qstat     i_qstat,
    output logic       o_stall,
    output logic       o_push,
    output t_group     o_group
);

    localparam logic [15:0] POS_MAX = (SOURCE_BYTES > 65536) ? 16'hFFFF
                                                              : 16'(SOURCE_BYTES - 1);
    localparam logic [16:0] LEN_MAX = (SOURCE_BYTES > 65536) ? 17'h10000
                                                              : 17'(SOURCE_BYTES);

    t_mode       r_mode, n_mode;
    logic [15:0] r_start, n_start;
    logic [15:0] r_pos, n_pos;
    logic [6:0]  r_kw, n_kw;
    logic [7:0]  r_first, n_first;
    logic [16:0] r_len, n_len;

    logic        accept;
    t_group      grp;

    // what a byte does when it lands between tokens
    t_mode       f_mode;
    logic [6:0]  f_kw;
    logic        f_begin;
    logic        f_emit;
    logic [4:0]  f_kind;

    function automatic logic [15:0] sat_pos(input logic [17:0] v);
        return (v > {2'b00, POS_MAX}) ? POS_MAX : v[15:0];
    endfunction

    function automatic logic [16:0] inc_len(input logic [16:0] v);
        return (v >= LEN_MAX) ? LEN_MAX : v + 17'd1;
    endfunction

    function automatic t_group add(input t_group g, input logic [4:0] kind,
                                   input logic [15:0] start, input logic [16:0] len,
                                   input logic [7:0] first);
        t_group r;
        r = g;
        r.tok[r.cnt] = t_token'{kind, start, len, first};
        r.cnt = r.cnt + 2'd1;
        return r;
    endfunction

    function automatic logic [4:0] ident_kind(input logic [6:0] kw, input logic [16:0] len,
                                              input logic boundary);
        logic [4:0] kind;
        kind = TK_IDENT;
        if (boundary) begin
            for (int i = 0; i < C_KW_COUNT; i++) begin
                if (kw[i] && len == {14'd0, kw_len(3'(i))}) begin
                    kind = kw_type(3'(i));
                end
            end
        end
        return kind;
    endfunction

    function automatic logic [4:0] single_op(input logic [7:0] p);
        if (p == CH_EQ) begin
            return TK_ASSIGN;
        end else if (p == CH_BANG) begin
            return TK_NOT;
        end else if (p == CH_LT || p == CH_GT) begin
            return TK_RELOP;
        end
        return TK_ERROR;
    endfunction

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;

    always_comb begin
        logic [7:0] b;
        b       = i_source_byte;
        f_mode  = MODE_IDLE;
        f_kw    = '0;
        f_begin = 1'b0;
        f_emit  = 1'b0;
        f_kind  = TK_ERROR;
        if (is_space(b)) begin
            f_mode = MODE_IDLE;
        end else if (b == CH_QUOTE) begin
            f_mode  = MODE_STRING;
            f_begin = 1'b1;
        end else if (is_alpha(b)) begin
            f_mode  = MODE_IDENT;
            f_begin = 1'b1;
            for (int i = 0; i < C_KW_COUNT; i++) begin
                f_kw[i] = (kw_char(3'(i), 3'd0) == b);
            end
        end else if (is_digit(b)) begin
            f_mode  = MODE_INT;
            f_begin = 1'b1;
        end else if (b == CH_EQ || b == CH_BANG || b == CH_LT || b == CH_GT ||
                     b == CH_AMP || b == CH_PIPE) begin
            f_mode  = MODE_OP;
            f_begin = 1'b1;
        end else begin
            f_emit = 1'b1;
            unique case (b) inside
                CH_PLUS, CH_MINUS: f_kind = TK_ADDOP;
                CH_STAR, CH_SLASH: f_kind = TK_MULOP;
                CH_SEMI:           f_kind = TK_SEMI;
                CH_COMMA:          f_kind = TK_COMMA;
                CH_LPAREN:         f_kind = TK_LPAREN;
                CH_RPAREN:         f_kind = TK_RPAREN;
                CH_LBRACE:         f_kind = TK_LBRACE;
                CH_RBRACE:         f_kind = TK_RBRACE;
                CH_DOLLAR:         f_kind = TK_DOLLAR;
                default:           f_kind = TK_ERROR;
            endcase
        end
    end

    always_comb begin
        logic [7:0]  b;
        logic [15:0] pos;
        logic [16:0] ilen;
        logic [17:0] dot_pos;
        logic        do_fresh;
        b        = i_source_byte;
        pos      = r_pos;
        ilen     = '0;
        dot_pos  = '0;
        do_fresh = 1'b0;
        grp      = '0;
        n_mode   = r_mode;
        n_start  = r_start;
        n_pos    = r_pos;
        n_kw     = r_kw;
        n_first  = r_first;
        n_len    = r_len;

        unique case (r_mode)
            MODE_IDENT: begin
                if (is_alpha(b) || is_digit(b)) begin
                    for (int i = 0; i < C_KW_COUNT; i++) begin
                        if (!(r_len < {14'd0, kw_len(3'(i))} &&
                              kw_char(3'(i), r_len[2:0]) == b)) begin
                            n_kw[i] = 1'b0;
                        end
                    end
                    n_len = inc_len(r_len);
                end else begin
                    grp = add(grp, ident_kind(r_kw, r_len, b != CH_UNDERSCORE),
                              r_start, r_len, r_first);
                    do_fresh = 1'b1;
                end
            end
            MODE_INT: begin
                if (is_digit(b)) begin
                    n_len = inc_len(r_len);
                end else if (b == CH_DOT) begin
                    n_len  = inc_len(r_len);
                    n_mode = MODE_INTDOT;
                end else begin
                    grp = add(grp, TK_INT, r_start, r_len, r_first);
                    do_fresh = 1'b1;
                end
            end
            MODE_INTDOT: begin
                if (is_digit(b)) begin
                    n_len  = inc_len(r_len);
                    n_mode = MODE_REAL;
                end else begin
                    // integer part, then the stray dot
                    ilen    = (r_len > 17'd1) ? r_len - 17'd1 : 17'd1;
                    dot_pos = {2'b00, r_start} + {1'b0, ilen};
                    grp = add(grp, TK_INT, r_start, ilen, r_first);
                    grp = add(grp, TK_ERROR, sat_pos(dot_pos), 17'd1, CH_DOT);
                    do_fresh = 1'b1;
                end
            end
            MODE_REAL: begin
                if (is_digit(b)) begin
                    n_len = inc_len(r_len);
                end else begin
                    grp = add(grp, TK_REAL, r_start, r_len, r_first);
                    do_fresh = 1'b1;
                end
            end
            MODE_STRING: begin
                n_len = inc_len(r_len);
                if (b == CH_QUOTE) begin
                    grp    = add(grp, TK_STRING, r_start, inc_len(r_len), r_first);
                    n_mode = MODE_IDLE;
                end
            end
            MODE_OP: begin
                if ((r_first == CH_EQ || r_first == CH_BANG) && b == CH_EQ) begin
                    grp    = add(grp, TK_EQOP, r_start, 17'd2, r_first);
                    n_mode = MODE_IDLE;
                end else if ((r_first == CH_LT || r_first == CH_GT) && b == CH_EQ) begin
                    grp    = add(grp, TK_RELOP, r_start, 17'd2, r_first);
                    n_mode = MODE_IDLE;
                end else if (r_first == CH_AMP && b == CH_AMP) begin
                    grp    = add(grp, TK_AND, r_start, 17'd2, r_first);
                    n_mode = MODE_IDLE;
                end else if (r_first == CH_PIPE && b == CH_PIPE) begin
                    grp    = add(grp, TK_OR, r_start, 17'd2, r_first);
                    n_mode = MODE_IDLE;
                end else begin
                    grp = add(grp, single_op(r_first), r_start, 17'd1, r_first);
                    do_fresh = 1'b1;
                end
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase

        if (do_fresh) begin
            n_mode = f_mode;
            n_kw   = f_kw;
            if (f_begin) begin
                n_start = pos;
                n_first = b;
                n_len   = 17'd1;
            end
            if (f_emit) begin
                grp = add(grp, f_kind, pos, 17'd1, b);
            end
        end

        if (i_end_of_source) begin
            // flush whatever token is still open
            case (n_mode)
                MODE_IDENT:  grp = add(grp, ident_kind(n_kw, n_len, 1'b1),
                                       n_start, n_len, n_first);
                MODE_INT:    grp = add(grp, TK_INT, n_start, n_len, n_first);
                MODE_INTDOT: begin
                    ilen    = (n_len > 17'd1) ? n_len - 17'd1 : 17'd1;
                    dot_pos = {2'b00, n_start} + {1'b0, ilen};
                    grp = add(grp, TK_INT, n_start, ilen, n_first);
                    grp = add(grp, TK_ERROR, sat_pos(dot_pos), 17'd1, CH_DOT);
                end
                MODE_REAL:   grp = add(grp, TK_REAL, n_start, n_len, n_first);
                MODE_STRING: grp = add(grp, TK_ERROR, n_start, 17'd1, CH_QUOTE);
                MODE_OP:     grp = add(grp, single_op(n_first), n_start, 17'd1, n_first);
                default:     grp = grp;
            endcase
            n_mode = MODE_IDLE;
            n_kw   = '0;
            n_pos  = '0;
        end else begin
            n_pos = sat_pos({2'b00, pos} + 18'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_pos   <= '0;
            r_kw    <= '0;
            r_first <= '0;
            r_len   <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_kw    <= n_kw;
            r_first <= n_first;
            r_len   <= n_len;
        end
    end

    assign o_push  = accept && (grp.cnt != 2'd0);
    assign o_group = grp;

endmodule

FILE: design/clx_queue.sv
// Short FIFO of token groups between the scanner and the output serializer.
// Depends on clx_pkg.
module clx_queue import clx_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    input  logic   i_pop,
    output t_qstat o_qstat,
    output t_group o_head
);

    localparam int QW = $clog2(C_QUEUE_DEPTH);

    t_group          r_mem [C_QUEUE_DEPTH];
    logic [QW-1:0]   r_wr;
    logic [QW-1:0]   r_rd;
    logic [QW:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QW+1)'(1);
                2'b01:   r_count <= r_count - (QW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == (QW+1)'(C_QUEUE_DEPTH));
    assign o_head        = r_mem[r_rd];

endmodule

FILE: design/clx_back.sv
// Output serializer: hands out the tokens of the head group one word at a time.
// Depends on clx_pkg.
module clx_back import clx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_group      i_head,
    input  t_qstat      i_qstat,
    input  logic        i_stall,
    output logic        o_pop,
    output logic        o_valid,
    output logic [4:0]  o_token_type,
    output logic [15:0] o_start_offset,
    output logic [16:0] o_token_length,
    output logic [7:0]  o_first_symbol,
    output logic        o_last_of_run
);

    logic [1:0] r_idx;
    t_token     tok;
    logic       last;
    logic       take;

    assign tok     = i_head.tok[r_idx];
    assign last    = (r_idx == i_head.cnt - 2'd1);
    assign o_valid = !i_qstat.empty;
    assign take    = o_valid && !i_stall;
    assign o_pop   = take && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end

    assign o_token_type   = tok.kind;
    assign o_start_offset = tok.start;
    assign o_token_length = tok.len;
    assign o_first_symbol = tok.first;
    assign o_last_of_run  = last;

endmodule

FILE: design/c_subset_lexer.sv
// Top level of the streaming lexer: scanner, token-group queue, output serializer.
// Depends on clx_pkg, clx_front, clx_queue, clx_back.

// Takes one source byte per cycle whenever o_stall is low, and emits tokens as type,
// start offset, length and first byte, one word per cycle while i_stall is low. A
// byte can close a token, add a single-byte token and (with end_of_source) flush the
// open one, so it causes 0 to 3 output words; o_last_of_run marks the last of them.
// Input and output are decoupled by a 4-entry queue of per-byte token groups: the
// scanner keeps taking bytes while the queue has room, and the output side drains
// one token per cycle while i_stall is low, so the sustained rate is one byte per
// cycle as long as bytes average no more than one token each. An accepted byte's
// group is registered in the queue before its first token is output. Offsets
// saturate at min(SOURCE_BYTES,65536)-1 and lengths at min(SOURCE_BYTES,65536);
// after the end_of_source byte the position returns to zero for the next source.
module c_subset_lexer import clx_pkg::*; #(
    parameter int unsigned SOURCE_BYTES = C_SOURCE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_source_byte,
    input  logic        i_end_of_source,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_token_type,
    output logic [15:0] o_start_offset,
    output logic [16:0] o_token_length,
    output logic [7:0]  o_first_symbol,
    output logic        o_last_of_run
);

    t_qstat qstat;
    t_group push_group;
    t_group head;
    logic   push;
    logic   pop;

    clx_front #(
        .SOURCE_BYTES(SOURCE_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_source_byte  (i_source_byte),
        .i_end_of_source(i_end_of_source),
        .i_qstat        (qstat),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_group        (push_group)
    );

    clx_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_group(push_group),
        .i_pop  (pop),
        .o_qstat(qstat),
        .o_head (head)
    );

    clx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_qstat       (qstat),
        .i_stall       (i_stall),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_token_type  (o_token_type),
        .o_start_offset(o_start_offset),
        .o_token_length(o_token_length),
        .o_first_symbol(o_first_symbol),
        .o_last_of_run (o_last_of_run)
    );

endmodule

FILE: design/clx_checker.sv
// Port-level checks for the lexer, attached to the top level by bind.
// Depends on clx_pkg and c_subset_lexer.
module clx_checker import clx_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_source_byte,
    input logic        i_end_of_source,
    input logic        o_valid,
    input logic        i_stall,
    input logic [4:0]  o_token_type,
    input logic [15:0] o_start_offset,
    input logic [16:0] o_token_length,
    input logic [7:0]  o_first_symbol,
    input logic        o_last_of_run
);

    // reset empties the queue on both sides
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("lexer not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_type) &&
            $stable(o_start_offset) && $stable(o_token_length) &&
            $stable(o_first_symbol) && $stable(o_last_of_run))
        else $error("stalled output word changed");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_token_length != 17'd0 && o_token_type <= TK_ERROR)
        else $error("bad token word");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_type == TK_ERROR |-> o_token_length == 17'd1)
        else $error("error token longer than one byte");

    a_string_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_type == TK_STRING |->
            o_first_symbol == CH_QUOTE && o_token_length >= 17'd2)
        else $error("string token without opening quote");

endmodule

bind c_subset_lexer clx_checker u_chk (.*);
